### hdl/cmta_pkg.sv
package cmta_pkg;

  localparam int COORD_BITS     = 16;
  localparam int QUOT_FRAC_BITS = 16;
  localparam int INDEX_BITS     = 12;
  localparam int FACE_BITS      = 3;
  localparam int DIV_STEPS      = QUOT_FRAC_BITS + 1;

  localparam logic [INDEX_BITS-1:0] LAST_INDEX_RESET = INDEX_BITS'(1023);
  localparam logic [FACE_BITS-1:0]  FACE_NEG_X       = FACE_BITS'(1);

  typedef struct packed {
    logic                      vld;
    logic                      zero;
    logic [FACE_BITS-1:0]      face;
    logic [COORD_BITS-1:0]     mag;
    logic [COORD_BITS-1:0]     rem0;
    logic [COORD_BITS-1:0]     rem1;
    logic [1:0]                lo0;
    logic [1:0]                lo1;
    logic [QUOT_FRAC_BITS:0]   quo0;
    logic [QUOT_FRAC_BITS:0]   quo1;
  } div_stage_t;

endpackage

### hdl/cube_map_texel_address.sv
// Pipeline: 1 face select, 17 divider cells, 1 scale and output stage.
// Throughput: one request per cycle while the output is not stalled.
// The divider is a chain of 17 cells, one quotient bit each, both coordinates.
// A stalled output holds the whole chain.
// Reset clears all valid bits and loads last_index_q with 1023.
module cube_map_texel_address import cmta_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [COORD_BITS-1:0] dir_x_i,
  input  logic signed [COORD_BITS-1:0] dir_y_i,
  input  logic signed [COORD_BITS-1:0] dir_z_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [FACE_BITS-1:0]         face_o,
  output logic [INDEX_BITS-1:0]        texel_row_o,
  output logic [INDEX_BITS-1:0]        texel_col_o,
  output logic                         zero_vector_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [INDEX_BITS-1:0]        cfg_data_i
);

  logic                  adv;
  logic [INDEX_BITS-1:0] last_index_q;
  div_stage_t            chain [DIV_STEPS+1];

  // hold every stage while a finished result waits
  assign adv         = !(valid_o && stall_i);
  assign stall_o     = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= LAST_INDEX_RESET;
    end else if (cfg_valid_i) begin
      last_index_q <= cfg_data_i;
    end
  end

  cmta_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (valid_i),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .stage_o (chain[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    cmta_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  cmta_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .stage_i       (chain[DIV_STEPS]),
    .last_index_i  (last_index_q),
    .vld_o         (valid_o),
    .face_o        (face_o),
    .texel_row_o   (texel_row_o),
    .texel_col_o   (texel_col_o),
    .zero_vector_o (zero_vector_o)
  );

endmodule

### hdl/cmta_front.sv
module cmta_front import cmta_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic signed [COORD_BITS-1:0] dir_x_i,
  input  logic signed [COORD_BITS-1:0] dir_y_i,
  input  logic signed [COORD_BITS-1:0] dir_z_i,
  output div_stage_t                   stage_o
);

  logic [COORD_BITS-1:0]   mag_x, mag_y, mag_z, mag_m;
  logic [1:0]              major;
  logic                    neg;
  logic signed [COORD_BITS-1:0] rem_a, rem_b;
  logic signed [COORD_BITS+1:0] num_a, num_b;
  logic [COORD_BITS:0]     n0, n1;
  div_stage_t              stage_d, stage_q;

  assign mag_x = dir_x_i[COORD_BITS-1] ? COORD_BITS'(-dir_x_i) : dir_x_i;
  assign mag_y = dir_y_i[COORD_BITS-1] ? COORD_BITS'(-dir_y_i) : dir_y_i;
  assign mag_z = dir_z_i[COORD_BITS-1] ? COORD_BITS'(-dir_z_i) : dir_z_i;

  always_comb begin
    // first axis wins a tie
    if (mag_z > ((mag_y > mag_x) ? mag_y : mag_x)) begin
      major = 2'd2;
      mag_m = mag_z;
      neg   = dir_z_i[COORD_BITS-1];
      rem_a = dir_x_i;
      rem_b = dir_y_i;
    end else if (mag_y > mag_x) begin
      major = 2'd1;
      mag_m = mag_y;
      neg   = dir_y_i[COORD_BITS-1];
      rem_a = dir_x_i;
      rem_b = dir_z_i;
    end else begin
      major = 2'd0;
      mag_m = mag_x;
      neg   = dir_x_i[COORD_BITS-1];
      rem_a = dir_y_i;
      rem_b = dir_z_i;
    end
    num_a = neg ? ($signed({2'b00, mag_m}) - (COORD_BITS+2)'(rem_a))
                : ($signed({2'b00, mag_m}) + (COORD_BITS+2)'(rem_a));
    num_b = neg ? ($signed({2'b00, mag_m}) - (COORD_BITS+2)'(rem_b))
                : ($signed({2'b00, mag_m}) + (COORD_BITS+2)'(rem_b));
    n0 = num_a[COORD_BITS+1] ? '0 : num_a[COORD_BITS:0];
    n1 = num_b[COORD_BITS+1] ? '0 : num_b[COORD_BITS:0];

    stage_d.vld  = vld_i;
    stage_d.zero = (mag_m == '0);
    stage_d.face = stage_d.zero ? FACE_NEG_X : FACE_BITS'({major, neg});
    stage_d.mag  = mag_m;
    // upper dividend bits, known to stay below the divisor
    stage_d.rem0 = COORD_BITS'(n0[COORD_BITS:2]);
    stage_d.rem1 = COORD_BITS'(n1[COORD_BITS:2]);
    stage_d.lo0  = n0[1:0];
    stage_d.lo1  = n1[1:0];
    stage_d.quo0 = '0;
    stage_d.quo1 = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### hdl/cmta_div_cell.sv
module cmta_div_cell import cmta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  div_stage_t stage_i,
  output div_stage_t stage_o
);

  logic [COORD_BITS:0] part0, part1;
  logic                ge0, ge1;
  div_stage_t          stage_d, stage_q;

  always_comb begin
    part0 = {stage_i.rem0, stage_i.lo0[1]};
    part1 = {stage_i.rem1, stage_i.lo1[1]};
    ge0   = part0 >= {1'b0, stage_i.mag};
    ge1   = part1 >= {1'b0, stage_i.mag};
    stage_d      = stage_i;
    stage_d.rem0 = COORD_BITS'(ge0 ? (part0 - {1'b0, stage_i.mag}) : part0);
    stage_d.rem1 = COORD_BITS'(ge1 ? (part1 - {1'b0, stage_i.mag}) : part1);
    stage_d.lo0  = {stage_i.lo0[0], 1'b0};
    stage_d.lo1  = {stage_i.lo1[0], 1'b0};
    stage_d.quo0 = {stage_i.quo0[QUOT_FRAC_BITS-1:0], ge0};
    stage_d.quo1 = {stage_i.quo1[QUOT_FRAC_BITS-1:0], ge1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### hdl/cmta_scale.sv
module cmta_scale import cmta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  div_stage_t            stage_i,
  input  logic [INDEX_BITS-1:0] last_index_i,
  output logic                  vld_o,
  output logic [FACE_BITS-1:0]  face_o,
  output logic [INDEX_BITS-1:0] texel_row_o,
  output logic [INDEX_BITS-1:0] texel_col_o,
  output logic                  zero_vector_o
);

  localparam logic [QUOT_FRAC_BITS:0] ONE = {1'b1, {QUOT_FRAC_BITS{1'b0}}};
  localparam int PW = QUOT_FRAC_BITS + 1 + INDEX_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (QUOT_FRAC_BITS - 1);

  logic [QUOT_FRAC_BITS:0] u0, u1;
  logic [PW-1:0]           p0, p1;
  logic                    vld_q, zero_q;
  logic [FACE_BITS-1:0]    face_q;
  logic [INDEX_BITS-1:0]   row_d, col_d, row_q, col_q;

  always_comb begin
    u0 = (stage_i.quo0 > ONE) ? ONE : stage_i.quo0;
    u1 = (stage_i.quo1 > ONE) ? ONE : stage_i.quo1;
    p0 = PW'(u0) * PW'(last_index_i) + HALF;
    p1 = PW'(u1) * PW'(last_index_i) + HALF;
    col_d = stage_i.zero ? '0 : p0[QUOT_FRAC_BITS +: INDEX_BITS];
    row_d = stage_i.zero ? '0 : p1[QUOT_FRAC_BITS +: INDEX_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= stage_i.zero;
      face_q <= stage_i.face;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  assign vld_o         = vld_q;
  assign face_o        = face_q;
  assign texel_row_o   = row_q;
  assign texel_col_o   = col_q;
  assign zero_vector_o = zero_q;

endmodule
